FILE: src/prefixed_salt_text_decoder_core_assert.svh
// Assertion macros shared by the salt text decoder modules.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef PREFIXED_SALT_TEXT_DECODER_CORE_ASSERT_SVH
`define PREFIXED_SALT_TEXT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PSTD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pstd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PSTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pstd assertion failed");

`endif

FILE: src/pstd_pkg.sv
// Package for the salt text decoder: modes, FSM states, control structs,
// character constants and the character decode functions. No dependencies.
package pstd_pkg;

  typedef enum logic [1:0] {
    MODE_PREFIX,
    MODE_HEX,
    MODE_B64,
    MODE_IDLE
  } mode_t;

  typedef enum logic [1:0] {
    CS_RUN,
    CS_REPLAY,
    CS_FINISH
  } ctl_state_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_ODD_HEX  = 2'd2;

  localparam logic [7:0] CH_PAD      = 8'h3D;  // '='
  localparam logic [3:0] BITS_RESET  = 4'b1000; // -8
  localparam logic [1:0] CAND_BOTH   = 2'b11;
  localparam int         HOLD_DEPTH  = 6;
  localparam logic [2:0] HEX_PFX_LEN = 3'd4;
  localparam logic [2:0] B64_PFX_LEN = 3'd7;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_replay;
    logic last_step;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    mode_t       mode;
    logic [13:0] acc;
    logic [3:0]  bits;
    logic [1:0]  err;
    logic [7:0]  dat;
    logic        ok;
  } b64_res_t;

  // "hex:"
  function automatic logic [7:0] pfx_hex_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h68;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h78;
      3'd3:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "base64:"
  function automatic logic [7:0] pfx_b64_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h73;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h36;
      3'd5:    ch = 8'h34;
      3'd6:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {ok, index} in the standard base64 alphabet
  function automatic logic [6:0] b64_index(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // {ok, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  // One base64 character into the accumulator; bits is two's complement
  function automatic b64_res_t b64_feed(input mode_t m, input logic [13:0] acc,
                                        input logic [3:0] bits, input logic [1:0] err,
                                        input logic [7:0] c);
    b64_res_t   r;
    logic [6:0] ix;
    logic [4:0] sum;
    logic [13:0] sh;
    r.mode = m;
    r.acc  = acc;
    r.bits = bits;
    r.err  = err;
    r.dat  = 8'h00;
    r.ok   = 1'b0;
    ix  = b64_index(c);
    sum = 5'h00;
    sh  = 14'h0;
    if (m == MODE_B64) begin
      if (c == CH_PAD) begin
        r.mode = MODE_IDLE;
      end else if (!ix[6]) begin
        r.err  = ST_BAD_CHAR;
        r.mode = MODE_IDLE;
      end else begin
        r.acc = {acc[7:0], ix[5:0]};
        sum   = {bits[3], bits} + 5'd6;
        if (!sum[4]) begin
          sh     = r.acc >> sum[2:0];
          r.dat  = sh[7:0];
          r.ok   = 1'b1;
          r.bits = sum[3:0] - 4'd8;
        end else begin
          r.bits = sum[3:0];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] end_status(input logic [1:0] err, input mode_t m,
                                            input logic np);
    logic [1:0] s;
    if (err != ST_OK) s = err;
    else if (m == MODE_HEX && np) s = ST_ODD_HEX;
    else s = ST_OK;
    return s;
  endfunction

endpackage

FILE: src/pstd_ctrl.sv
// Controller FSM of the salt text decoder: input handshake and sequencing
// of the prefix replay. Depends on pstd_pkg and the assertion header.
`include "prefixed_salt_text_decoder_core_assert.svh"

module pstd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pstd_pkg::dp_sts_t sts,
  output pstd_pkg::dp_cmd_t cmd
);
  import pstd_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_RUN: begin
        if (in_valid && sts.out_free && sts.need_replay) state_nxt = CS_REPLAY;
      end
      CS_REPLAY: begin
        if (sts.out_free && sts.last_step) state_nxt = CS_FINISH;
      end
      CS_FINISH: begin
        if (sts.out_free) state_nxt = CS_RUN;
      end
      default: state_nxt = CS_RUN;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      CS_RUN: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
      end
      CS_REPLAY: cmd.step   = sts.out_free;
      CS_FINISH: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

  `PSTD_ASSERT_SAME(a_ready_only_run, state_r != CS_RUN, !in_ready)
  `PSTD_ASSERT_NEXT(a_replay_entry, cmd.accept && sts.need_replay, state_r == CS_REPLAY)
  `PSTD_ASSERT_NEXT(a_finish_returns, cmd.finish, state_r == CS_RUN)

endmodule

FILE: src/pstd_datapath.sv
// Datapath of the salt text decoder: prefix match and hold, hex and base64
// decode state, replay byte buffer, output register. Depends on pstd_pkg and the assertion header.
`include "prefixed_salt_text_decoder_core_assert.svh"

module pstd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_char_code,
  input  logic              in_char_valid,
  input  logic              in_last_char,
  input  pstd_pkg::dp_cmd_t cmd,
  output pstd_pkg::dp_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_run_end,
  output logic              out_done_res,
  output logic [1:0]        out_status
);
  import pstd_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  cand_r, cand_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic        np_r, np_nxt;
  logic [13:0] acc_r, acc_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [7:0]  hold_r [HOLD_DEPTH];
  logic        hold_we;
  logic [7:0]  cur_r, cur_nxt;
  logic        fcur_r, fcur_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  ri_r, ri_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic        hv_r, hv_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_bv_r, out_re_r, out_done_r;
  logic [1:0]  out_st_r;

  logic        out_free;
  logic        hex_m, b64_m, hex_done, b64_done, pfx_done;
  logic [1:0]  cand;
  logic [2:0]  cnt_after;
  logic        need_replay;
  logic [7:0]  rep_char;
  mode_t       dir_mode, rep_mode;
  b64_res_t    fa, fr;
  logic [4:0]  hd;

  logic        push, push_bv, push_re, push_done, clear;
  logic [7:0]  push_dat;
  logic [1:0]  push_st;

  assign out_free = !out_valid_r || out_ready;

  // prefix candidate match against the current character
  assign hex_m    = cand_r[0] && (cnt_r < HEX_PFX_LEN) && (in_char_code == pfx_hex_char(cnt_r));
  assign b64_m    = cand_r[1] && (cnt_r < B64_PFX_LEN) && (in_char_code == pfx_b64_char(cnt_r));
  assign cand     = {b64_m, hex_m};
  assign hex_done = hex_m && (cnt_r == HEX_PFX_LEN - 3'd1);
  assign b64_done = b64_m && (cnt_r == B64_PFX_LEN - 3'd1);
  assign pfx_done = in_char_valid && (hex_done || b64_done);

  always_comb begin
    if (pfx_done) cnt_after = 3'd0;
    else if (in_char_valid && cand != 2'b00 && cnt_r < 3'(HOLD_DEPTH)) cnt_after = cnt_r + 3'd1;
    else cnt_after = cnt_r;
  end

  // replay is needed when held characters must be decoded as base64
  assign need_replay = (mode_r == MODE_PREFIX) &&
                       ((in_char_valid && cand == 2'b00 && cnt_r != 3'd0) ||
                        (in_last_char && cnt_after != 3'd0));

  assign rep_char = (ri_r < cnt_r) ? hold_r[ri_r] : cur_r;
  assign dir_mode = (mode_r == MODE_PREFIX) ? MODE_B64 : mode_r;
  assign rep_mode = (mode_r == MODE_PREFIX) ? MODE_B64 : mode_r;
  assign fa       = b64_feed(dir_mode, acc_r, bits_r, err_r, in_char_code);
  assign fr       = b64_feed(rep_mode, acc_r, bits_r, err_r, rep_char);
  assign hd       = hex_digit(in_char_code);

  assign sts.need_replay = need_replay;
  assign sts.last_step   = fcur_r ? (ri_r == cnt_r) : (ri_r == cnt_r - 3'd1);
  assign sts.out_free    = out_free;

  always_comb begin
    mode_t      w_mode;
    logic [1:0] w_err;
    logic       w_np;
    logic       bv;
    logic [7:0] bd;
    w_mode    = mode_r;
    w_err     = err_r;
    w_np      = np_r;
    bv        = 1'b0;
    bd        = 8'h00;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    cand_nxt  = cand_r;
    hn_nxt    = hn_r;
    np_nxt    = np_r;
    acc_nxt   = acc_r;
    bits_nxt  = bits_r;
    err_nxt   = err_r;
    cur_nxt   = cur_r;
    fcur_nxt  = fcur_r;
    last_nxt  = last_r;
    ri_nxt    = ri_r;
    hb_nxt    = hb_r;
    hv_nxt    = hv_r;
    hold_we   = 1'b0;
    push      = 1'b0;
    push_dat  = 8'h00;
    push_bv   = 1'b0;
    push_re   = 1'b0;
    push_done = 1'b0;
    push_st   = ST_OK;
    clear     = 1'b0;

    if (cmd.accept) begin
      cur_nxt  = in_char_code;
      fcur_nxt = in_char_valid && (cand == 2'b00);
      last_nxt = in_last_char;
      ri_nxt   = 3'd0;
      if (mode_r == MODE_PREFIX && in_char_valid && cand != 2'b00 && !pfx_done &&
          cnt_r < 3'(HOLD_DEPTH)) begin
        hold_we  = 1'b1;
        cand_nxt = cand;
      end
      if (need_replay) begin
        cnt_nxt = cnt_after;
      end else begin
        case (mode_r)
          MODE_PREFIX: begin
            if (in_char_valid) begin
              if (cand == 2'b00) begin
                // nothing held: decode this character as base64 at once
                w_mode   = fa.mode;
                acc_nxt  = fa.acc;
                bits_nxt = fa.bits;
                w_err    = fa.err;
                bv       = fa.ok;
                bd       = fa.dat;
              end else if (hex_done) begin
                w_mode  = MODE_HEX;
                cnt_nxt = 3'd0;
              end else if (b64_done) begin
                w_mode  = MODE_B64;
                cnt_nxt = 3'd0;
              end else begin
                cnt_nxt = cnt_after;
              end
            end
          end
          MODE_HEX: begin
            if (in_char_valid) begin
              if (!hd[4]) begin
                w_err  = ST_BAD_CHAR;
                w_mode = MODE_IDLE;
              end else if (np_r) begin
                bv   = 1'b1;
                bd   = {hn_r, hd[3:0]};
                w_np = 1'b0;
              end else begin
                hn_nxt = hd[3:0];
                w_np   = 1'b1;
              end
            end
          end
          MODE_B64: begin
            if (in_char_valid) begin
              w_mode   = fa.mode;
              acc_nxt  = fa.acc;
              bits_nxt = fa.bits;
              w_err    = fa.err;
              bv       = fa.ok;
              bd       = fa.dat;
            end
          end
          default: ;
        endcase
        mode_nxt = w_mode;
        err_nxt  = w_err;
        np_nxt   = w_np;
        if (in_last_char) begin
          push      = 1'b1;
          push_dat  = bd;
          push_bv   = bv;
          push_re   = 1'b1;
          push_done = 1'b1;
          push_st   = end_status(w_err, w_mode, w_np);
          clear     = 1'b1;
        end else if (bv) begin
          push     = 1'b1;
          push_dat = bd;
          push_bv  = 1'b1;
          push_re  = 1'b1;
        end
      end
    end else if (cmd.step) begin
      mode_nxt = fr.mode;
      acc_nxt  = fr.acc;
      bits_nxt = fr.bits;
      err_nxt  = fr.err;
      ri_nxt   = ri_r + 3'd1;
      if (fr.ok) begin
        // a byte already buffered is known not to be the last of the item
        if (hv_r) begin
          push     = 1'b1;
          push_dat = hb_r;
          push_bv  = 1'b1;
        end
        hb_nxt = fr.dat;
        hv_nxt = 1'b1;
      end
    end else if (cmd.finish) begin
      cnt_nxt = 3'd0;
      hv_nxt  = 1'b0;
      if (hv_r) begin
        push      = 1'b1;
        push_dat  = hb_r;
        push_bv   = 1'b1;
        push_re   = 1'b1;
        push_done = last_r;
        push_st   = last_r ? end_status(err_r, mode_r, np_r) : ST_OK;
      end else if (last_r) begin
        push      = 1'b1;
        push_re   = 1'b1;
        push_done = 1'b1;
        push_st   = end_status(err_r, mode_r, np_r);
      end
      clear = last_r;
    end

    if (clear) begin
      mode_nxt = MODE_PREFIX;
      cnt_nxt  = 3'd0;
      cand_nxt = CAND_BOTH;
      hn_nxt   = 4'h0;
      np_nxt   = 1'b0;
      acc_nxt  = 14'h0;
      bits_nxt = BITS_RESET;
      err_nxt  = ST_OK;
      hv_nxt   = 1'b0;
    end
  end

  always_comb begin
    if (push) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PREFIX;
      cnt_r       <= 3'd0;
      cand_r      <= CAND_BOTH;
      hn_r        <= 4'h0;
      np_r        <= 1'b0;
      acc_r       <= 14'h0;
      bits_r      <= BITS_RESET;
      err_r       <= ST_OK;
      fcur_r      <= 1'b0;
      last_r      <= 1'b0;
      ri_r        <= 3'd0;
      hv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      cand_r      <= cand_nxt;
      hn_r        <= hn_nxt;
      np_r        <= np_nxt;
      acc_r       <= acc_nxt;
      bits_r      <= bits_nxt;
      err_r       <= err_nxt;
      fcur_r      <= fcur_nxt;
      last_r      <= last_nxt;
      ri_r        <= ri_nxt;
      hv_r        <= hv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    hb_r  <= hb_nxt;
    if (hold_we) hold_r[cnt_r] <= in_char_code;
    if (push) begin
      out_byte_r <= push_dat;
      out_bv_r   <= push_bv;
      out_re_r   <= push_re;
      out_done_r <= push_done;
      out_st_r   <= push_st;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_run_end    = out_re_r;
  assign out_done_res   = out_done_r;
  assign out_status     = out_st_r;

  // bits held between characters is one of -8, -6, -4, -2
  `PSTD_ASSERT_SAME(a_work_needs_room, cmd.step || cmd.finish || cmd.accept, out_free)
  `PSTD_ASSERT_SAME(a_bits_range, 1'b1, bits_r[3] && !bits_r[0])
  `PSTD_ASSERT_NEXT(a_end_clears, cmd.accept && !need_replay && in_last_char,
                    mode_r == MODE_PREFIX && cnt_r == 3'd0 && !hv_r)

endmodule

FILE: src/prefixed_salt_text_decoder_core.sv
// Top level of the salt text decoder: controller plus datapath.
// Depends on pstd_pkg, pstd_ctrl and pstd_datapath.
//
// Usage: text arrives one character per item on the in_ channel
// (in_char_code, in_char_valid, in_last_char; in_char_valid low with
// in_last_char high ends the string, empty or not). Decoded bytes leave
// on the out_ channel; out_run_end marks the last result of an input
// item, and out_done_res with out_status marks the final result of a string.
// Timing: an item that needs no replay shows its result the cycle after it
// is accepted, so one character per cycle is sustained while the receiver
// keeps up. When the prefix match fails, or the string ends during it, the
// held characters (up to six) and then the failing character are fed one
// per cycle through the base64 unit while the output register is free, and
// a finish step then closes the item: in_ready stays low until it is
// closed, and the results of such an item leave during those steps.
// Every result passes through a single output register; while it is full
// and out_ready is low, nothing advances and in_ready stays low.
// Reset (rst_n low at a clock edge) empties the output register and returns
// the decoder to prefix matching; each string's end also returns it there.
module prefixed_salt_text_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_char_valid,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_end,
  output logic       out_done_res,
  output logic [1:0] out_status
);
  import pstd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pstd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pstd_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_code   (in_char_code),
    .in_char_valid  (in_char_valid),
    .in_last_char   (in_last_char),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_end    (out_run_end),
    .out_done_res   (out_done_res),
    .out_status     (out_status)
  );

endmodule

FILE: bench/tb_prefixed_salt_text_decoder_core.sv
// Self-checking bench for prefixed_salt_text_decoder_core: directed strings, then random text.
// Typed rows set their item; a model predicts the rest. Depends on pstd_pkg and the core RTL.
module tb_prefixed_salt_text_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pstd_pkg::*;

  localparam int RAND_ITEMS  = 400;
  localparam int MAX_PER_ITM = 5;
  localparam int LONG_HOLD   = 80;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_TAIL  = 16;
  localparam int DIR_N       = 26;

  localparam logic [31:0] HEX_TAG = "hex:";
  localparam logic [55:0] B64_TAG = "base64:";

  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       run_end;
    logic       done;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [7:0] code;
    logic       cv;
    logic       lst;
    logic       typed;
    logic [7:0] t_byte;
    logic       t_bv;
    logic       t_done;
    logic [1:0] t_status;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic       in_char_valid;
  logic       in_last_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_run_end;
  logic       out_done_res;
  logic [1:0] out_status;

  prefixed_salt_text_decoder_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_char_valid (in_char_valid),
    .in_last_char  (in_last_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_run_end   (out_run_end),
    .out_done_res  (out_done_res),
    .out_status    (out_status)
  );

  // Decoder model state
  mode_t       dm_mode;
  logic [7:0]  dm_hold [6];
  int          dm_held;
  logic [1:0]  dm_cand;
  logic [3:0]  dm_hi_nib;
  logic        dm_nib_pend;
  logic [13:0] dm_acc;
  int          dm_bits;
  logic [1:0]  dm_err;

  result_t     item_res [MAX_PER_ITM];
  int          n_res;
  result_t     decoded_due [$];

  int mismatches   = 0;
  int items_sent   = 0;
  bit steady_phase = 1'b0;
  bit hold_req     = 1'b0;

  dir_row_t dir_tab [DIR_N] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_OK},       // empty string
    '{8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_BAD_CHAR},
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_BAD_CHAR},
    '{"=",   1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_OK},
    '{"/",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"/",   1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, ST_OK},
    '{"h",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"e",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"x",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{":",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"f",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"F",   1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, ST_OK},
    '{"0",   1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_ODD_HEX},
    '{"b",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"a",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"s",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"e",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"6",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"4",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"x",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // six held + one: five bytes
    '{8'hA5, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // end item mid-string
    '{"h",   1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // ends inside the prefix
    '{"Q",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // no character, ignored
    '{"=",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},
    '{"A",   1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK}        // after padding: ignored
  };

  function automatic logic [7:0] hex_tag_char(input int p);
    return HEX_TAG[8*(3-p) +: 8];
  endfunction

  function automatic logic [7:0] b64_tag_char(input int p);
    return B64_TAG[8*(6-p) +: 8];
  endfunction

  function automatic int b64_value(input logic [7:0] c);
    int v;
    v = -1;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 26;
    else if (c >= "0" && c <= "9") v = c - "0" + 52;
    else if (c == "+") v = 62;
    else if (c == "/") v = 63;
    return v;
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    int v;
    v = -1;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    return v;
  endfunction

  function automatic logic [7:0] rand_b64_char();
    int v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'(65 + v);
    if (v < 52) return 8'(97 + v - 26);
    if (v < 62) return 8'(48 + v - 52);
    return (v == 62) ? "+" : "/";
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(48 + v);
    if (v < 16) return 8'(97 + v - 10);
    return 8'(65 + v - 16);
  endfunction

  task automatic clear_decoder();
    dm_mode     = MODE_PREFIX;
    dm_held     = 0;
    dm_cand     = 2'b11;
    dm_hi_nib   = '0;
    dm_nib_pend = 1'b0;
    dm_acc      = '0;
    dm_bits     = -8;
    dm_err      = ST_OK;
  endtask

  task automatic emit(input logic [7:0] b, input logic bv);
    if (n_res < MAX_PER_ITM) begin
      item_res[n_res] = '{data: b, byte_ok: bv, run_end: 1'b0, done: 1'b0, status: ST_OK};
      n_res++;
    end
  endtask

  task automatic b64_take(input logic [7:0] c);
    int v;
    logic [13:0] sh;
    v = b64_value(c);
    if (dm_mode == MODE_B64) begin
      if (c == "=") begin
        dm_mode = MODE_IDLE;
      end else if (v < 0) begin
        dm_err  = ST_BAD_CHAR;
        dm_mode = MODE_IDLE;
      end else begin
        dm_acc  = {dm_acc[7:0], 6'(v)};
        dm_bits = dm_bits + 6;
        if (dm_bits >= 0) begin
          sh = dm_acc >> dm_bits;
          emit(sh[7:0], 1'b1);
          dm_bits = dm_bits - 8;
        end
      end
    end
  endtask

  task automatic hex_take(input logic [7:0] c);
    int v;
    v = nibble_of(c);
    if (v < 0) begin
      dm_err  = ST_BAD_CHAR;
      dm_mode = MODE_IDLE;
    end else if (dm_nib_pend) begin
      emit({dm_hi_nib, 4'(v)}, 1'b1);
      dm_nib_pend = 1'b0;
    end else begin
      dm_hi_nib   = 4'(v);
      dm_nib_pend = 1'b1;
    end
  endtask

  // Held characters go back through base64 once no prefix can match or the string ends
  task automatic replay_hold();
    dm_mode = MODE_B64;
    for (int i = 0; i < dm_held && i < 6; i++) b64_take(dm_hold[i]);
    dm_held = 0;
  endtask

  task automatic prefix_take(input logic [7:0] c);
    int p;
    logic [1:0] m;
    p = dm_held;
    m = 2'b00;
    if (dm_cand[0] && p < 4 && c == hex_tag_char(p)) m[0] = 1'b1;
    if (dm_cand[1] && p < 7 && c == b64_tag_char(p)) m[1] = 1'b1;
    if (m == 2'b00) begin
      replay_hold();
      b64_take(c);
    end else if (m[0] && p == 3) begin
      dm_mode = MODE_HEX;
      dm_held = 0;
    end else if (m[1] && p == 6) begin
      dm_mode = MODE_B64;
      dm_held = 0;
    end else if (p < 6) begin
      dm_hold[p] = c;
      dm_held    = p + 1;
      dm_cand    = m;
    end
  endtask

  // Output items caused by one input item, left in item_res[0:n_res-1]
  task automatic decode_step(input logic [7:0] c, input logic cv, input logic lst);
    logic [1:0] st;
    n_res = 0;
    if (cv) begin
      case (dm_mode)
        MODE_PREFIX: prefix_take(c);
        MODE_HEX:    hex_take(c);
        MODE_B64:    b64_take(c);
        default:     ;
      endcase
    end
    if (lst) begin
      if (dm_mode == MODE_PREFIX) replay_hold();
      st = dm_err;
      if (st == ST_OK && dm_mode == MODE_HEX && dm_nib_pend) st = ST_ODD_HEX;
      if (n_res == 0) emit(8'h00, 1'b0);
      item_res[n_res-1].done   = 1'b1;
      item_res[n_res-1].status = st;
      clear_decoder();
    end
    if (n_res > 0) item_res[n_res-1].run_end = 1'b1;
  endtask

  task automatic send_item(input logic [7:0] c, input logic cv, input logic lst,
                           input logic typed, input result_t typed_res);
    if (!steady_phase && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= c;
    in_char_valid <= cv;
    in_last_char  <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_step(c, cv, lst);
    if (typed) decoded_due = {decoded_due, typed_res};
    else for (int i = 0; i < n_res; i++) decoded_due = {decoded_due, item_res[i]};
    if (cv || lst) items_sent++;
  endtask

  task automatic send_string();
    logic [7:0] txt [$];
    int kind, n, k;
    logic sep_end;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(0, 10);
    case (kind)
      0, 1, 2: begin
        for (k = 0; k < 4; k++) txt = {txt, hex_tag_char(k)};
        for (k = 0; k < n; k++) txt = {txt, rand_hex_char()};
        if ($urandom_range(0, 7) == 0)
          txt.insert($urandom_range(4, txt.size()), 8'($urandom_range(0, 255)));
      end
      3, 4, 5: begin
        for (k = 0; k < 7; k++) txt = {txt, b64_tag_char(k)};
        for (k = 0; k < n; k++) txt = {txt, rand_b64_char()};
        if ($urandom_range(0, 3) == 0) begin
          txt = {txt, 8'("=")};
          if ($urandom_range(0, 1) == 0) txt = {txt, 8'("=")};
          repeat ($urandom_range(0, 2)) txt = {txt, rand_b64_char()};
        end
        if ($urandom_range(0, 7) == 0)
          txt.insert($urandom_range(7, txt.size()), 8'($urandom_range(0, 255)));
      end
      6, 7: begin
        for (k = 0; k < n; k++) txt = {txt, rand_b64_char()};
      end
      8: begin
        // prefix that breaks off part way
        if ($urandom_range(0, 1) == 0) begin
          for (k = 0; k < $urandom_range(1, 3); k++) txt = {txt, hex_tag_char(k)};
        end else begin
          for (k = 0; k < $urandom_range(1, 6); k++) txt = {txt, b64_tag_char(k)};
        end
        if ($urandom_range(0, 3) != 0) txt = {txt, 8'($urandom_range(0, 255))};
        repeat ($urandom_range(0, 4)) txt = {txt, rand_b64_char()};
      end
      default: begin
        for (k = 0; k < n; k++) txt = {txt, 8'($urandom_range(0, 255))};
      end
    endcase
    sep_end = (txt.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (txt[j]) begin
      if (!steady_phase && $urandom_range(0, 9) == 0)
        send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      send_item(txt[j], 1'b1, !sep_end && (j == txt.size() - 1), 1'b0, '0);
    end
    if (sep_end) send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
  endtask

  task automatic wait_all_decoded();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else if (stall == 0 && !steady_phase && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    got = '{data: out_byte, byte_ok: out_byte_valid, run_end: out_run_end,
            done: out_done_res, status: out_status};
    if (rst_n && out_valid && out_ready) begin
      if (decoded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected item byte=%h bv=%b end=%b done=%b st=%0d", $realtime,
                   got.data, got.byte_ok, got.run_end, got.done, got.status);
      end else begin
        want = decoded_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp byte=%h bv=%b end=%b done=%b st=%0d", $realtime,
                     want.data, want.byte_ok, want.run_end, want.done, want.status);
            $display("    got byte=%h bv=%b end=%b done=%b st=%0d",
                     got.data, got.byte_ok, got.run_end, got.done, got.status);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no item moving on either side
  initial begin
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) still = 0;
      else still++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    result_t typed_res;
    int rand_base;
    bit held, drained;
    held          = 1'b0;
    drained       = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_char_code  <= 8'h00;
    in_char_valid <= 1'b0;
    in_last_char  <= 1'b0;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      typed_res = '{data: dir_tab[i].t_byte, byte_ok: dir_tab[i].t_bv, run_end: 1'b1,
                    done: dir_tab[i].t_done, status: dir_tab[i].t_status};
      send_item(dir_tab[i].code, dir_tab[i].cv, dir_tab[i].lst, dir_tab[i].typed, typed_res);
    end

    rand_base = items_sent;
    while (items_sent < rand_base + RAND_ITEMS) begin
      if (!held && items_sent >= rand_base + 120) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!drained && items_sent >= rand_base + 250) begin
        wait_all_decoded();
        drained = 1'b1;
      end
      if (items_sent >= rand_base + 340) steady_phase = 1'b1;
      send_string();
    end

    wait_all_decoded();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
